@@ sv/kmq_pkg.sv @@
`timescale 1ns / 1ps
package kmq_pkg;

    localparam int NUM_KEYS = 512;
    localparam int KEY_AW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KEY_W    = 9;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SET    = 1'b1;

    localparam logic [2:0] MODE_PLAIN    = 3'd0;
    localparam logic [2:0] MODE_TOGGLE   = 3'd1;
    localparam logic [2:0] MODE_COOLDOWN = 3'd2;
    localparam logic [2:0] MODE_INSTANT  = 3'd3;
    localparam logic [2:0] MODE_CYCLE    = 3'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_kmq_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
    } t_kmq_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } t_kmq_sts;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  value;
        logic [15:0] cooldown;
        logic [7:0]  cycle;
        logic [31:0] last;
    } t_key_entry;

endpackage

@@ sv/kmq_ctrl.sv @@
`timescale 1ns / 1ps
module kmq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  kmq_pkg::t_kmq_sts i_sts,
    output kmq_pkg::t_kmq_cmd o_cmd,
    output logic              o_stall
);
    import kmq_pkg::*;

    t_kmq_state r_state;
    t_kmq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (!i_sts.out_blocked) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            ST_EXEC: begin
                // hold the request until the result register can take it
                o_cmd.exec = !i_sts.out_blocked;
            end
            default: o_cmd = '0;
        endcase
    end

    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!o_cmd.accept && !o_cmd.exec))
        else $error("request taken during table clear");

    a_accept_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == ST_EXEC))
        else $error("accepted request not followed by execute");

    a_exec_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> !i_sts.out_blocked)
        else $error("result register overwritten while held");

endmodule

@@ sv/kmq_dp.sv @@
`timescale 1ns / 1ps
module kmq_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kmq_pkg::t_kmq_cmd i_cmd,
    output kmq_pkg::t_kmq_sts o_sts,
    input  logic              i_opcode,
    input  logic [8:0]        i_key_index,
    input  logic              i_pressed,
    input  logic [31:0]       i_now_ms,
    input  logic [2:0]        i_mode,
    input  logic [7:0]        i_initial_value,
    input  logic [15:0]       i_cooldown_ms,
    input  logic [7:0]        i_cycle_count,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [8:0]        o_key_out,
    output logic [7:0]        o_key_value,
    output logic              o_fired
);
    import kmq_pkg::*;

    t_key_entry r_mem [NUM_KEYS];
    t_key_entry r_rdata;

    logic [KEY_AW-1:0] r_clr_addr;
    logic              r_out_valid;

    logic        r_op;
    logic [8:0]  r_key;
    logic        r_pressed;
    logic [31:0] r_now;
    logic [2:0]  r_mode;
    logic [7:0]  r_ival;
    logic [15:0] r_cd;
    logic [7:0]  r_cyc;

    logic [KEY_W+1:0]  key_ext;
    logic              in_range;
    logic [KEY_AW-1:0] wr_addr;
    logic [31:0]       elapsed;
    logic              gt;
    logic [8:0]        v_inc;
    t_key_entry        upd;
    logic              fire;

    assign o_sts.clear_last  = (r_clr_addr == KEY_AW'(NUM_KEYS - 1));
    assign o_sts.out_blocked = r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear && !o_sts.clear_last) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_opcode;
            r_key     <= i_key_index;
            r_pressed <= i_pressed;
            r_now     <= i_now_ms;
            r_mode    <= i_mode;
            r_ival    <= i_initial_value;
            r_cd      <= i_cooldown_ms;
            r_cyc     <= i_cycle_count;
        end
    end

    assign key_ext  = {2'b00, r_key};
    assign in_range = key_ext < (KEY_W + 2)'(NUM_KEYS);
    assign wr_addr  = KEY_AW'(r_key);

    assign elapsed = r_now - r_rdata.last;
    assign gt      = elapsed > {16'd0, r_rdata.cooldown};
    assign v_inc   = {1'b0, r_rdata.value} + 9'd1;

    always_comb begin
        upd  = r_rdata;
        fire = 1'b0;
        if (r_op == OP_SET) begin
            upd.mode     = r_mode;
            upd.value    = r_ival;
            upd.cooldown = r_cd;
            upd.cycle    = r_cyc;
        end else begin
            case (r_rdata.mode)
                MODE_TOGGLE: begin
                    fire = r_pressed && gt;
                    if (fire) begin
                        upd.value = {7'd0, ~r_rdata.value[0]};
                        upd.last  = r_now;
                    end
                    if (!r_pressed) upd.last = '0;
                end
                MODE_COOLDOWN: begin
                    fire = r_pressed && (r_rdata.value == 8'd0);
                    // a fresh press restarts timing, so it cannot expire at once
                    if (fire) begin
                        upd.value = 8'd1;
                        upd.last  = r_now;
                    end else if (gt) begin
                        upd.value = 8'd0;
                    end
                end
                MODE_INSTANT: begin
                    fire = r_pressed && gt && (r_rdata.value == 8'd0);
                    if (fire) begin
                        upd.value = 8'd1;
                        upd.last  = r_now;
                    end else if (!gt) begin
                        upd.value = 8'd0;
                    end
                end
                MODE_CYCLE: begin
                    fire = r_pressed && gt;
                    if (fire) begin
                        upd.value = (v_inc >= {1'b0, r_rdata.cycle}) ? 8'd0 : v_inc[7:0];
                        upd.last  = r_now;
                    end
                    if (!r_pressed) upd.last = '0;
                end
                default: begin
                    upd.value = {7'd0, r_pressed};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.exec && in_range) begin
            r_mem[wr_addr] <= upd;
        end
        if (i_cmd.accept) begin
            r_rdata <= r_mem[KEY_AW'(i_key_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_key_out   <= r_key;
            o_key_value <= in_range ? upd.value : 8'd0;
            o_fired     <= in_range && (r_op == OP_SAMPLE) && fire;
        end
    end

    assign o_valid = r_out_valid;

    a_exec_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> o_valid)
        else $error("executed request produced no result");

    a_set_never_fires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_op == OP_SET)) |=> !o_fired)
        else $error("set request reported a fired press");

    a_result_held_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_key_out)
                                  && $stable(o_key_value) && $stable(o_fired)))
        else $error("stalled result changed or dropped");

endmodule

@@ sv/key_mode_qualifier.sv @@
`timescale 1ns / 1ps
// Per-key press qualifier over a 512-entry key table (NUM_KEYS). For each
// request the accept step reads the key's table entry into a register, and the
// execute step writes the updated entry back and loads the result register, so
// a new request is taken only after the previous one has executed; a stalled
// result holds the block in its execute step. After reset a clearing pass
// zeroes the table one entry per cycle, with o_stall held high until it
// completes.
module key_mode_qualifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [8:0]  i_key_index,
    input  logic        i_pressed,
    input  logic [31:0] i_now_ms,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_initial_value,
    input  logic [15:0] i_cooldown_ms,
    input  logic [7:0]  i_cycle_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [8:0]  o_key_out,
    output logic [7:0]  o_key_value,
    output logic        o_fired
);
    import kmq_pkg::*;

    t_kmq_cmd cmd;
    t_kmq_sts sts;

    kmq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    kmq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_key_index     (i_key_index),
        .i_pressed       (i_pressed),
        .i_now_ms        (i_now_ms),
        .i_mode          (i_mode),
        .i_initial_value (i_initial_value),
        .i_cooldown_ms   (i_cooldown_ms),
        .i_cycle_count   (i_cycle_count),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_key_out       (o_key_out),
        .o_key_value     (o_key_value),
        .o_fired         (o_fired)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import kmq_pkg::*;

    localparam int RANDOM_PER_PHASE = 475;
    localparam int LONG_HOLD        = 300;
    localparam int TAIL_CYCLES      = 20;

    typedef struct {
        logic        op;
        logic [8:0]  key;
        logic        pressed;
        logic [31:0] now;
        logic [2:0]  mode;
        logic [7:0]  ival;
        logic [15:0] cd;
        logic [7:0]  cyc;
    } t_key_req;

    typedef struct {
        logic [8:0] key;
        logic [7:0] value;
        logic       fired;
    } t_key_result;

    typedef struct {
        t_key_req   req;
        bit         typed;
        logic [7:0] value;
        logic       fired;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_opcode = 1'b0;
    logic [8:0]  i_key_index = '0;
    logic        i_pressed = 1'b0;
    logic [31:0] i_now_ms = '0;
    logic [2:0]  i_mode = '0;
    logic [7:0]  i_initial_value = '0;
    logic [15:0] i_cooldown_ms = '0;
    logic [7:0]  i_cycle_count = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [8:0]  o_key_out;
    logic [7:0]  o_key_value;
    logic        o_fired;

    // shadow copy of the key table
    logic [2:0]  mode_tbl [NUM_KEYS];
    logic [7:0]  val_tbl  [NUM_KEYS];
    logic [15:0] cd_tbl   [NUM_KEYS];
    logic [7:0]  cyc_tbl  [NUM_KEYS];
    logic [31:0] last_tbl [NUM_KEYS];

    t_key_result   pending_results [$];
    t_directed_row directed_rows [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_asked = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int error_count = 0;
    int requests_sent = 0;
    int sets_sent = 0;
    int results_checked = 0;
    int presses_fired = 0;
    logic [31:0] clock_ms;
    logic [8:0]  key_pool [8];

    key_mode_qualifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_key_index    (i_key_index),
        .i_pressed      (i_pressed),
        .i_now_ms       (i_now_ms),
        .i_mode         (i_mode),
        .i_initial_value(i_initial_value),
        .i_cooldown_ms  (i_cooldown_ms),
        .i_cycle_count  (i_cycle_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_key_out      (o_key_out),
        .o_key_value    (o_key_value),
        .o_fired        (o_fired)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic logic [31:0] since_press(input int k, input logic [31:0] now);
        return now - last_tbl[k];
    endfunction

    function automatic t_key_result qualify_key(input t_key_req r);
        t_key_result res;
        logic [7:0]  v;
        logic [31:0] cd;
        int          k;
        k = int'(r.key);
        res.key = r.key;
        res.value = '0;
        res.fired = 1'b0;
        if (k < NUM_KEYS) begin
            if (r.op == OP_SET) begin
                mode_tbl[k] = r.mode;
                val_tbl[k]  = r.ival;
                cd_tbl[k]   = r.cd;
                cyc_tbl[k]  = r.cyc;
            end else begin
                v  = val_tbl[k];
                cd = {16'd0, cd_tbl[k]};
                case (mode_tbl[k])
                    MODE_TOGGLE: begin
                        if (r.pressed && since_press(k, r.now) > cd) begin
                            v = {7'd0, ~v[0]};
                            last_tbl[k] = r.now;
                            res.fired = 1'b1;
                        end
                        if (!r.pressed)
                            last_tbl[k] = '0;
                    end
                    MODE_COOLDOWN: begin
                        if (r.pressed && v == 8'd0) begin
                            v = 8'd1;
                            last_tbl[k] = r.now;
                            res.fired = 1'b1;
                        end
                        // elapsed time is taken again after a possible restart
                        if (since_press(k, r.now) > cd)
                            v = 8'd0;
                    end
                    MODE_INSTANT: begin
                        if (v != 8'd0 && since_press(k, r.now) <= cd)
                            v = 8'd0;
                        if (r.pressed && v == 8'd0 && since_press(k, r.now) > cd) begin
                            v = 8'd1;
                            last_tbl[k] = r.now;
                            res.fired = 1'b1;
                        end
                    end
                    MODE_CYCLE: begin
                        if (r.pressed && since_press(k, r.now) > cd) begin
                            v = ({1'b0, v} + 9'd1 >= {1'b0, cyc_tbl[k]}) ? 8'd0 : v + 8'd1;
                            last_tbl[k] = r.now;
                            res.fired = 1'b1;
                        end
                        if (!r.pressed)
                            last_tbl[k] = '0;
                    end
                    default: begin
                        v = {7'd0, r.pressed};
                    end
                endcase
                val_tbl[k] = v;
            end
            res.value = val_tbl[k];
        end
        return res;
    endfunction

    task automatic send_request(input t_key_req r, input bit typed,
                                input logic [7:0] tv, input logic tf);
        t_key_result want;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= r.op;
        i_key_index     <= r.key;
        i_pressed       <= r.pressed;
        i_now_ms        <= r.now;
        i_mode          <= r.mode;
        i_initial_value <= r.ival;
        i_cooldown_ms   <= r.cd;
        i_cycle_count   <= r.cyc;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        want = qualify_key(r);
        if (typed) begin
            want.value = tv;
            want.fired = tf;
        end
        pending_results.push_back(want);
        requests_sent++;
        if (r.op == OP_SET)
            sets_sent++;
    endtask

    task automatic add_row(input logic op, input int key, input logic pressed,
                           input logic [31:0] now, input logic [2:0] mode, input int ival,
                           input int cd, input int cyc, input bit typed,
                           input int value, input logic fired);
        t_directed_row row;
        row.req.op      = op;
        row.req.key     = key[8:0];
        row.req.pressed = pressed;
        row.req.now     = now;
        row.req.mode    = mode;
        row.req.ival    = ival[7:0];
        row.req.cd      = cd[15:0];
        row.req.cyc     = cyc[7:0];
        row.typed       = typed;
        row.value       = value[7:0];
        row.fired       = fired;
        directed_rows.push_back(row);
    endtask

    task automatic gen_random_req(output t_key_req r);
        int pick;
        r.key = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, NUM_KEYS - 1))
                                            : key_pool[$urandom_range(0, 7)];
        r.op   = ($urandom_range(0, 99) < 15) ? OP_SET : OP_SAMPLE;
        r.mode = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                              : 3'($urandom_range(5, 7));
        r.ival = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            r.cd = 16'($urandom_range(0, 40));
        else if (pick < 85)
            r.cd = 16'($urandom);
        else
            r.cd = '0;
        r.cyc = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 6)) : 8'($urandom);
        r.pressed = ($urandom_range(0, 99) < 60);
        // mostly a steadily advancing clock so that elapsed times land near the cooldown
        if ($urandom_range(0, 99) < 5) begin
            r.now = $urandom;
        end else begin
            clock_ms = clock_ms + 32'($urandom_range(0, 25));
            r.now = clock_ms;
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct,
                             input bit long_hold, input bit drain_pause);
        t_key_req r;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < 8; i++)
            key_pool[i] = 9'($urandom_range(0, NUM_KEYS - 1));
        // start near the top now and then so the clock wraps during the phase
        clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FC00 + 32'($urandom_range(0, 255))
                                               : 32'($urandom);
        for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (long_hold && i == RANDOM_PER_PHASE / 2)
                hold_asked++;
            gen_random_req(r);
            send_request(r, 1'b0, '0, 1'b0);
            if (drain_pause && i == RANDOM_PER_PHASE / 3) begin
                i_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge i_clk);
            end
        end
    endtask

    task automatic check_result();
        t_key_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result for key %0d with no request pending", o_key_out));
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (o_fired === 1'b1)
            presses_fired++;
        if (o_key_out !== want.key)
            report_mismatch($sformatf("key_out got %0d want %0d", o_key_out, want.key));
        if (o_key_value !== want.value)
            report_mismatch($sformatf("key %0d key_value got %0d want %0d",
                                      want.key, o_key_value, want.value));
        if (o_fired !== want.fired)
            report_mismatch($sformatf("key %0d fired got %0b want %0b",
                                      want.key, o_fired, want.fired));
    endtask

    always @(posedge i_clk) begin
        if (o_valid === 1'b1 && i_stall == 1'b0)
            check_result();
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    initial begin
        int tail;
        for (int k = 0; k < NUM_KEYS; k++) begin
            mode_tbl[k] = MODE_PLAIN;
            val_tbl[k]  = '0;
            cd_tbl[k]   = '0;
            cyc_tbl[k]  = '0;
            last_tbl[k] = '0;
        end

        // op, key, pressed, now, mode, value, cooldown, cycles, typed, value, fired
        add_row(OP_SAMPLE, 0, 1'b0, 32'd0, MODE_PLAIN, 0, 0, 0, 1, 0, 1'b0);
        add_row(OP_SAMPLE, 511, 1'b1, 32'hFFFF_FFFF, MODE_PLAIN, 0, 0, 0, 1, 1, 1'b0);
        add_row(OP_SET, 511, 1'b0, 32'd0, 3'd7, 255, 65535, 255, 1, 255, 1'b0);
        add_row(OP_SAMPLE, 511, 1'b0, 32'd1, MODE_PLAIN, 0, 0, 0, 1, 0, 1'b0);
        add_row(OP_SET, 1, 1'b0, 32'd0, MODE_TOGGLE, 0, 0, 0, 1, 0, 1'b0);
        add_row(OP_SAMPLE, 1, 1'b1, 32'd5, MODE_PLAIN, 0, 0, 0, 1, 1, 1'b1);
        add_row(OP_SAMPLE, 1, 1'b1, 32'd5, MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(OP_SAMPLE, 1, 1'b0, 32'd6, MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(OP_SET, 2, 1'b0, 32'd0, MODE_COOLDOWN, 0, 10, 0, 1, 0, 1'b0);
        add_row(OP_SAMPLE, 2, 1'b1, 32'd100, MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(OP_SAMPLE, 2, 1'b0, 32'd111, MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(OP_SET, 3, 1'b0, 32'd0, MODE_INSTANT, 1, 20, 0, 1, 1, 1'b0);
        add_row(OP_SAMPLE, 3, 1'b1, 32'd10, MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(OP_SAMPLE, 3, 1'b1, 32'd50, MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(OP_SAMPLE, 3, 1'b1, 32'd60, MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(OP_SET, 4, 1'b0, 32'd0, MODE_CYCLE, 0, 0, 3, 1, 0, 1'b0);
        for (int t = 1; t <= 4; t++)
            add_row(OP_SAMPLE, 4, 1'b1, 32'(t), MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);
        // cycle key with a zero count always steps back to zero
        add_row(OP_SET, 5, 1'b0, 32'd0, MODE_CYCLE, 7, 0, 0, 1, 7, 1'b0);
        add_row(OP_SAMPLE, 5, 1'b1, 32'd1, MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);
        // elapsed time across the 32-bit wrap against the largest cooldown
        add_row(OP_SET, 6, 1'b0, 32'd0, MODE_TOGGLE, 0, 65535, 0, 1, 0, 1'b0);
        add_row(OP_SAMPLE, 6, 1'b1, 32'hFFFF_FFF0, MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(OP_SAMPLE, 6, 1'b1, 32'h0000_FFEF, MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(OP_SAMPLE, 6, 1'b1, 32'h0000_FFF0, MODE_PLAIN, 0, 0, 0, 0, 0, 1'b0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].value, directed_rows[i].fired);

        run_phase(0, 0, 1'b0, 1'b1);
        run_phase(45, 0, 1'b0, 1'b0);
        run_phase(0, 45, 1'b1, 1'b0);
        run_phase(6, 6, 1'b0, 1'b0);

        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        tail = TAIL_CYCLES;
        while (tail > 0) begin
            @(posedge i_clk);
            tail--;
        end

        $display("Sent %0d requests (%0d property loads) over all five key modes and unused codes,",
                 requests_sent, sets_sent);
        $display("checked %0d results, %0d of them fired presses, under sender and receiver stalls.",
                 results_checked, presses_fired);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ key_mode_qualifier.f @@
sv/kmq_pkg.sv
sv/kmq_ctrl.sv
sv/kmq_dp.sv
sv/key_mode_qualifier.sv
verif/tb_top.sv
